/* hw/rtl/bfsa_pkg.sv */
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and constants of the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 16;
  localparam int ID_BITS      = 8;
  localparam int SIZE_W       = ADDR_BITS + 1;
  localparam int CUR_W        = ADDR_BITS + 2;
  localparam logic [SIZE_W-1:0] CAP_MAX = SIZE_W'(1) << ADDR_BITS;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_COMPACT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFIT    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_PR,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FIND_RD,
    S_FIND_PR,
    S_DEL_RD,
    S_DEL_WR,
    S_CMP_RD,
    S_CMP_PR
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_BITS-1:0] owner_id;
    logic [SIZE_W-1:0]  request_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] placed_start;
  } out_word_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   owner;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    length;
  } entry_t;

  typedef struct packed {
    logic             gt;
    logic             fits;
    logic             better;
    logic [CUR_W-1:0] diff;
  } hole_res_t;

endpackage

/* hw/rtl/bfsa_ram.sv */
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/bfsa_hole_unit.sv */
// ----------------------------------------------------------------------------
// bfsa_hole_unit
// Shared subtract/compare unit: hole size, fit and best-fit test.
// ----------------------------------------------------------------------------
module bfsa_hole_unit (
  input  logic [bfsa_pkg::CUR_W-1:0]  cursor_i,
  input  logic [bfsa_pkg::CUR_W-1:0]  hole_end_i,
  input  logic [bfsa_pkg::SIZE_W-1:0] size_i,
  input  logic                        found_i,
  input  logic [bfsa_pkg::CUR_W-1:0]  best_size_i,
  output bfsa_pkg::hole_res_t         res_o
);

  logic [bfsa_pkg::CUR_W-1:0] diff;

  assign diff = hole_end_i - cursor_i;

  always_comb begin
    res_o.gt     = hole_end_i > cursor_i;
    res_o.diff   = diff;
    res_o.fits   = res_o.gt && (diff >= bfsa_pkg::CUR_W'(size_i));
    res_o.better = res_o.fits && (!found_i || (diff < best_size_i));
  end

endmodule

/* hw/rtl/bfsa_seq.sv */
// ----------------------------------------------------------------------------
// bfsa_seq
// Sequencer: walks the segment table in RAM for allocate, free and compact.
// ----------------------------------------------------------------------------
module bfsa_seq #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS,
  localparam int AW    = $clog2(MAX_SEGMENTS),
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  bfsa_pkg::in_word_t          cmd_i,
  input  logic [bfsa_pkg::SIZE_W-1:0] cap_i,
  output logic                        busy_o,
  output logic                        done_o,
  output bfsa_pkg::out_word_t         res_o
);

  localparam int EW = $bits(bfsa_pkg::entry_t);

  bfsa_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d, count_q, count_d, best_idx_q, best_idx_d;
  logic [bfsa_pkg::CUR_W-1:0] cursor_q, cursor_d, best_size_q, best_size_d;
  logic [bfsa_pkg::ADDR_BITS-1:0] best_start_q, best_start_d;
  logic found_q, found_d;
  bfsa_pkg::in_word_t cmd_q, cmd_d;
  logic done_q, done_d;
  bfsa_pkg::out_word_t res_q, res_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  bfsa_pkg::entry_t wdata, rdata;
  logic [EW-1:0] rdata_raw;

  logic [bfsa_pkg::CUR_W-1:0] hole_end;
  bfsa_pkg::hole_res_t hr;

  bfsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = bfsa_pkg::entry_t'(rdata_raw);

  assign hole_end = (state_q == bfsa_pkg::S_SCAN_RD) ? bfsa_pkg::CUR_W'(cap_i)
                                                     : bfsa_pkg::CUR_W'(rdata.start);

  bfsa_hole_unit u_hole (
    .cursor_i    (cursor_q),
    .hole_end_i  (hole_end),
    .size_i      (cmd_q.request_size),
    .found_i     (found_q),
    .best_size_i (best_size_q),
    .res_o       (hr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfsa_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    best_idx_q   <= best_idx_d;
    cursor_q     <= cursor_d;
    best_size_q  <= best_size_d;
    best_start_q <= best_start_d;
    found_q      <= found_d;
    cmd_q        <= cmd_d;
    res_q        <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    best_idx_d   = best_idx_q;
    cursor_d     = cursor_q;
    best_size_d  = best_size_q;
    best_start_d = best_start_q;
    found_d      = found_q;
    cmd_d        = cmd_q;
    done_d       = 1'b0;
    res_d        = res_q;
    we           = 1'b0;
    waddr        = idx_q[AW-1:0];
    wdata        = rdata;
    raddr        = idx_q[AW-1:0];

    unique case (state_q)
      bfsa_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          idx_d    = '0;
          cursor_d = '0;
          found_d  = 1'b0;
          res_d    = '0;
          unique case (bfsa_pkg::kind_e'(cmd_i.kind))
            bfsa_pkg::KIND_ALLOC: begin
              if (count_q == CNT_W'(MAX_SEGMENTS)) begin
                res_d.status = bfsa_pkg::STAT_FULL;
                done_d       = 1'b1;
              end else if (cmd_i.request_size == '0) begin
                res_d.status = bfsa_pkg::STAT_NOFIT;
                done_d       = 1'b1;
              end else begin
                state_d = bfsa_pkg::S_SCAN_RD;
              end
            end
            bfsa_pkg::KIND_FREE:    state_d = bfsa_pkg::S_FIND_RD;
            bfsa_pkg::KIND_COMPACT: state_d = bfsa_pkg::S_CMP_RD;
            default: begin
              res_d.status = bfsa_pkg::STAT_OK;
              done_d       = 1'b1;
            end
          endcase
        end
      end
      bfsa_pkg::S_SCAN_RD: begin
        if (idx_q < count_q) begin
          state_d = bfsa_pkg::S_SCAN_PR;
        end else if (hr.better || found_q) begin
          if (hr.better) begin
            best_size_d  = hr.diff;
            best_start_d = cursor_q[bfsa_pkg::ADDR_BITS-1:0];
            best_idx_d   = idx_q;
          end
          state_d = bfsa_pkg::S_SHIFT_RD;
        end else begin
          res_d.status = bfsa_pkg::STAT_NOFIT;
          done_d       = 1'b1;
          state_d      = bfsa_pkg::S_IDLE;
        end
      end
      bfsa_pkg::S_SCAN_PR: begin
        if (hr.better) begin
          found_d      = 1'b1;
          best_size_d  = hr.diff;
          best_start_d = cursor_q[bfsa_pkg::ADDR_BITS-1:0];
          best_idx_d   = idx_q;
        end
        cursor_d = bfsa_pkg::CUR_W'(rdata.start) + bfsa_pkg::CUR_W'(rdata.length);
        idx_d    = idx_q + 1'b1;
        state_d  = bfsa_pkg::S_SCAN_RD;
      end
      bfsa_pkg::S_SHIFT_RD: begin
        raddr = AW'(idx_q - 1'b1);
        if (idx_q > best_idx_q) begin
          state_d = bfsa_pkg::S_SHIFT_WR;
        end else begin
          state_d = bfsa_pkg::S_PUT;
        end
      end
      bfsa_pkg::S_SHIFT_WR: begin
        we      = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = bfsa_pkg::S_SHIFT_RD;
      end
      bfsa_pkg::S_PUT: begin
        we                 = 1'b1;
        waddr              = best_idx_q[AW-1:0];
        wdata.owner        = cmd_q.owner_id;
        wdata.start        = best_start_q;
        wdata.length       = cmd_q.request_size;
        count_d            = count_q + 1'b1;
        res_d.status       = bfsa_pkg::STAT_OK;
        res_d.placed_start = best_start_q;
        done_d             = 1'b1;
        state_d            = bfsa_pkg::S_IDLE;
      end
      bfsa_pkg::S_FIND_RD: begin
        if (idx_q < count_q) begin
          state_d = bfsa_pkg::S_FIND_PR;
        end else begin
          res_d.status = bfsa_pkg::STAT_NOTFOUND;
          done_d       = 1'b1;
          state_d      = bfsa_pkg::S_IDLE;
        end
      end
      bfsa_pkg::S_FIND_PR: begin
        if (rdata.owner == cmd_q.owner_id) begin
          state_d = bfsa_pkg::S_DEL_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = bfsa_pkg::S_FIND_RD;
        end
      end
      bfsa_pkg::S_DEL_RD: begin
        raddr = AW'(idx_q + 1'b1);
        if (({1'b0, idx_q} + 1'b1) < {1'b0, count_q}) begin
          state_d = bfsa_pkg::S_DEL_WR;
        end else begin
          count_d      = count_q - 1'b1;
          res_d.status = bfsa_pkg::STAT_OK;
          done_d       = 1'b1;
          state_d      = bfsa_pkg::S_IDLE;
        end
      end
      bfsa_pkg::S_DEL_WR: begin
        we      = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = bfsa_pkg::S_DEL_RD;
      end
      bfsa_pkg::S_CMP_RD: begin
        if (idx_q < count_q) begin
          state_d = bfsa_pkg::S_CMP_PR;
        end else begin
          res_d.status = bfsa_pkg::STAT_OK;
          done_d       = 1'b1;
          state_d      = bfsa_pkg::S_IDLE;
        end
      end
      bfsa_pkg::S_CMP_PR: begin
        we = 1'b1;
        if (hr.gt) begin
          wdata.start = cursor_q[bfsa_pkg::ADDR_BITS-1:0];
        end
        cursor_d = bfsa_pkg::CUR_W'(wdata.start) + bfsa_pkg::CUR_W'(rdata.length);
        idx_d    = idx_q + 1'b1;
        state_d  = bfsa_pkg::S_CMP_RD;
      end
      default: state_d = bfsa_pkg::S_IDLE;
    endcase
  end

  assign busy_o = (state_q != bfsa_pkg::S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
    else $error("segment count moved by more than one");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == bfsa_pkg::S_IDLE))
    else $error("result strobe while sequencer busy");

  a_start_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_q))
    else $error("accepted word produced no activity");
`endif

endmodule

/* hw/rtl/best_fit_segment_allocator_top.sv */
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_top
// Best-fit segment allocator over a configurable address space.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o low; busy_o stays high until
// the result, which shows on res_o with done_o high for exactly one cycle and
// cannot be stalled; res_o then holds it until the next word is taken. Free
// finds the owner's entry and shifts the later entries down; compact and
// allocate visit every entry, and allocate then shifts entries up to make room.
// Each entry visited takes a read state and a process state, as the segment
// table RAM has registered read data. Full-table and zero-size allocates and
// the unused kind finish without leaving idle. Capacity writes are taken at any time.
module best_fit_segment_allocator_top #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  bfsa_pkg::in_word_t          cmd_i,
  output logic                        done_o,
  output bfsa_pkg::out_word_t         res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bfsa_pkg::SIZE_W-1:0] cfg_data_i
);

  logic [bfsa_pkg::SIZE_W-1:0] cap_q, cap_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        cap_d = bfsa_pkg::SIZE_W'(1);
      end else if (cfg_data_i > bfsa_pkg::CAP_MAX) begin
        cap_d = bfsa_pkg::CAP_MAX;
      end else begin
        cap_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bfsa_pkg::CAP_MAX;
    end else begin
      cap_q <= cap_d;
    end
  end

  bfsa_seq #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .cap_i  (cap_q),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
